>>> hdl/gpw_pkg.sv
// shared types, constants and codes for the group projector weight block
// no dependencies
`default_nettype none
package gpw_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int NODE_AW    = $clog2(MAX_NODES);
   localparam int NODE_CW    = NODE_AW + 1;
   localparam int GROUP_SLOTS = 1024;
   localparam int GROUP_AW   = 10;
   localparam int PROB_W     = 16;
   localparam int COUNT_W    = 11;
   localparam int MASS_W     = 26;
   localparam int WFRAC      = 16;
   localparam int WEIGHT_W   = WFRAC + 1;
   localparam int STEPS      = WFRAC + 1;
   localparam int STEP_W     = $clog2(STEPS + 1);
   localparam int NODE_ENT_W = GROUP_AW + PROB_W;
   localparam int GRP_ENT_W  = COUNT_W + MASS_W;
   localparam int REQ_W      = 40;
   localparam int RSP_W      = 48;
   localparam int CSR_W      = 2;

   localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = WEIGHT_W'(1) << WFRAC;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_SYM   = 2'd0,
      KIND_LAP   = 2'd1,
      KIND_STOCH = 2'd2,
      KIND_RSVD  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_GROUP = 2'd1,
      ST_ZERO_MASS = 2'd2,
      ST_NO_NODE   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_KIND = 1'b0,
      CSR_ROW  = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_QNODE,
      S_QGRP,
      S_CALC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic div_mode;
   } unit_ctrl_type;

endpackage
`default_nettype wire

>>> hdl/gpw_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none
module gpw_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> hdl/gpw_serial_unit.sv
// bit-serial unit: one quotient bit of p/mass or one root bit of 1/sqrt(count) per cycle
// depends on gpw_pkg
`default_nettype none
module gpw_serial_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gpw_pkg::unit_ctrl_type         ctrl,
   input  wire logic [gpw_pkg::PROB_W-1:0]     prob,
   input  wire logic [gpw_pkg::MASS_W-1:0]     mass,
   input  wire logic [gpw_pkg::COUNT_W-1:0]    count,
   output logic                                done,
   output logic      [gpw_pkg::WEIGHT_W-1:0]   result
);
   import gpw_pkg::*;

   localparam int P_W = 2 * WFRAC + 1;
   localparam int B_W = COUNT_W + 2 * WFRAC + 1;
   localparam int T_W = B_W + 1;
   localparam logic [T_W-1:0] NUM = T_W'(1) << (2 * WFRAC);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                mode_ff, mode_in;
   logic                zero_ff, zero_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [MASS_W-1:0]   rem_ff, rem_in;
   logic [WEIGHT_W-1:0] dvd_ff, dvd_in;
   logic [MASS_W-1:0]   mass_ff, mass_in;
   logic [P_W-1:0]      p_ff, p_in;
   logic [P_W-1:0]      a_ff, a_in;
   logic [B_W-1:0]      b_ff, b_in;

   logic [MASS_W:0] div_t;
   logic            div_ge;
   logic [T_W-1:0]  sq_t;
   logic            sq_ok;

   always_comb begin
      div_t  = {rem_ff, dvd_ff[WEIGHT_W-1]};
      div_ge = div_t >= {1'b0, mass_ff};
      sq_t   = T_W'(p_ff) + T_W'(a_ff) + T_W'(b_ff);
      sq_ok  = sq_t <= NUM;

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      zero_in = zero_ff;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      mass_in = mass_ff;
      p_in    = p_ff;
      a_in    = a_ff;
      b_in    = b_ff;

      if (ctrl.start) begin
         busy_in = 1'b1;
         mode_in = ctrl.div_mode;
         zero_in = count == '0;
         step_in = STEP_W'(STEPS);
         q_in    = '0;
         rem_in  = MASS_W'(prob >> 1);
         dvd_in  = {prob[0], {(WEIGHT_W-1){1'b0}}};
         mass_in = mass;
         p_in    = '0;
         a_in    = '0;
         b_in    = B_W'(count) << (2 * WFRAC);
      end else if (busy_ff) begin
         if (mode_ff) begin
            rem_in = div_ge ? MASS_W'(div_t - {1'b0, mass_ff}) : div_t[MASS_W-1:0];
            dvd_in = dvd_ff << 1;
            q_in   = {q_ff[WEIGHT_W-2:0], div_ge};
         end else begin
            if (sq_ok) begin
               p_in = sq_t[P_W-1:0];
               a_in = (a_ff >> 1) + b_ff[P_W-1:0];
            end else begin
               a_in = a_ff >> 1;
            end
            b_in = b_ff >> 2;
            q_in = {q_ff[WEIGHT_W-2:0], sq_ok};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      zero_ff <= zero_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      mass_ff <= mass_in;
      p_ff    <= p_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   assign done   = done_ff;
   assign result = (zero_ff && !mode_ff) ? '0 : q_ff;
endmodule
`default_nettype wire

>>> hdl/group_projector_weights.sv
// group projector weights top level: node and group stores, control and output register
// depends on gpw_pkg, gpw_ram, gpw_serial_unit
// load: node write then group update; query: two ram reads, 17 serial steps when the status is ok, result stage
// one request at a time; clear command sweeps all 1024 slots of the group store
// reset (synchronous): clearing pass of the group store, req_tready low meanwhile
`default_nettype none
module group_projector_weights (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // command[1:0], group_index[11:2], prob_weight[27:12], node_index[37:28], zero fill
   input  wire logic [gpw_pkg::REQ_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // node_group[9:0], left_weight[26:10], right_weight[43:27], status[45:44], zero fill
   output logic      [gpw_pkg::RSP_W-1:0]  rsp_tdata,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [gpw_pkg::CSR_W-1:0]  csr_wdata
);
   import gpw_pkg::*;

   state_type state_ff, state_in;

   logic [NODE_CW-1:0]  nodes_ff;
   logic [GROUP_AW-1:0] largest_ff;
   logic [1:0]          kind_ff;
   logic                row_ff;
   logic [GROUP_AW-1:0] clr_cnt_ff;
   logic [GROUP_AW-1:0] ld_grp_ff;
   logic [PROB_W-1:0]   ld_prob_ff;
   logic [GROUP_AW-1:0] res_group_ff;
   logic [WEIGHT_W-1:0] res_left_ff, res_right_ff;
   logic [1:0]          res_status_ff;
   logic                rsp_tvalid_ff;
   logic [RSP_W-1:0]    rsp_tdata_ff;

   logic [1:0]          in_cmd;
   logic [GROUP_AW-1:0] in_grp;
   logic [PROB_W-1:0]   in_prob;
   logic [NODE_AW-1:0]  in_node;
   logic                accept;
   logic                full;
   logic                node_miss;

   logic                  node_we;
   logic [NODE_ENT_W-1:0] node_rdata;
   logic                  grp_we;
   logic [GROUP_AW-1:0]   grp_waddr, grp_raddr;
   logic [GRP_ENT_W-1:0]  grp_wdata, grp_rdata;
   logic [COUNT_W-1:0]    grp_count;
   logic [MASS_W-1:0]     grp_mass;

   unit_ctrl_type         unit_ctrl;
   logic                  unit_done;
   logic [WEIGHT_W-1:0]   unit_result;

   logic bad_group;
   logic out_free;

   assign in_cmd    = req_tdata[1:0];
   assign in_grp    = req_tdata[11:2];
   assign in_prob   = req_tdata[27:12];
   assign in_node   = req_tdata[37:28];
   assign accept    = req_tvalid && req_tready;
   assign full      = nodes_ff == NODE_CW'(MAX_NODES);
   assign node_miss = NODE_CW'(in_node) >= nodes_ff;
   assign grp_count = grp_rdata[GRP_ENT_W-1:MASS_W];
   assign grp_mass  = grp_rdata[MASS_W-1:0];
   assign bad_group = NODE_CW'(largest_ff) >= nodes_ff;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   gpw_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_ENT_W)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (nodes_ff[NODE_AW-1:0]),
      .wdata ({in_prob, in_grp}),
      .raddr (in_node),
      .rdata (node_rdata)
   );

   gpw_ram #(.DEPTH(GROUP_SLOTS), .WIDTH(GRP_ENT_W)) u_group_ram (
      .clock (clock),
      .we    (grp_we),
      .waddr (grp_waddr),
      .wdata (grp_wdata),
      .raddr (grp_raddr),
      .rdata (grp_rdata)
   );

   gpw_serial_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (unit_ctrl),
      .prob   (ld_prob_ff),
      .mass   (grp_mass),
      .count  (grp_count),
      .done   (unit_done),
      .result (unit_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == {GROUP_AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (in_cmd)
                  CMD_LOAD:  state_in = full ? S_IDLE : S_LOAD;
                  CMD_QUERY: state_in = node_miss ? S_DONE : S_QNODE;
                  CMD_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD:  state_in = S_IDLE;
         S_QNODE: state_in = S_QGRP;
         S_QGRP: begin
            if (bad_group || (kind_ff == KIND_STOCH && grp_mass == '0)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (unit_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the control
   always_comb begin
      req_tready         = 1'b0;
      node_we            = 1'b0;
      grp_we             = 1'b0;
      grp_waddr          = ld_grp_ff;
      grp_wdata          = {grp_count + COUNT_W'(1), grp_mass + MASS_W'(ld_prob_ff)};
      grp_raddr          = in_grp;
      unit_ctrl.start    = 1'b0;
      unit_ctrl.div_mode = kind_ff == KIND_STOCH;
      unique case (state_ff)
         S_CLEAR: begin
            grp_we    = 1'b1;
            grp_waddr = clr_cnt_ff;
            grp_wdata = '0;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            node_we    = accept && in_cmd == CMD_LOAD && !full;
         end
         S_LOAD:  grp_we = 1'b1;
         S_QNODE: grp_raddr = node_rdata[GROUP_AW-1:0];
         S_QGRP:  unit_ctrl.start = !bad_group &&
                     !(kind_ff == KIND_STOCH && grp_mass == '0);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         nodes_ff      <= '0;
         largest_ff    <= '0;
         kind_ff       <= KIND_SYM;
         row_ff        <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KIND: kind_ff <= csr_wdata;
               default:  row_ff  <= csr_wdata[0];
            endcase
         end
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + GROUP_AW'(1);
         end
         if (state_ff == S_IDLE && accept && in_cmd == CMD_CLEAR) begin
            clr_cnt_ff <= '0;
            nodes_ff   <= '0;
            largest_ff <= '0;
         end
         if (state_ff == S_LOAD) begin
            nodes_ff <= nodes_ff + NODE_CW'(1);
            if (ld_grp_ff > largest_ff) begin
               largest_ff <= ld_grp_ff;
            end
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            ld_grp_ff     <= in_grp;
            ld_prob_ff    <= in_prob;
            res_group_ff  <= '0;
            res_left_ff   <= '0;
            res_right_ff  <= '0;
            res_status_ff <= ST_NO_NODE;
         end
         S_QNODE: begin
            ld_grp_ff    <= node_rdata[GROUP_AW-1:0];
            ld_prob_ff   <= node_rdata[NODE_ENT_W-1:GROUP_AW];
            res_group_ff <= node_rdata[GROUP_AW-1:0];
         end
         S_QGRP: begin
            res_left_ff   <= '0;
            res_right_ff  <= '0;
            res_status_ff <= bad_group ? ST_BAD_GROUP : ST_ZERO_MASS;
         end
         S_CALC: begin
            res_status_ff <= ST_OK;
            case (kind_ff)
               KIND_STOCH: begin
                  res_left_ff  <= row_ff ? unit_result : ONE_WEIGHT;
                  res_right_ff <= row_ff ? ONE_WEIGHT : unit_result;
               end
               KIND_LAP: begin
                  res_left_ff  <= row_ff ? ONE_WEIGHT : unit_result;
                  res_right_ff <= row_ff ? unit_result : ONE_WEIGHT;
               end
               default: begin
                  res_left_ff  <= unit_result;
                  res_right_ff <= unit_result;
               end
            endcase
         end
         default: begin
         end
      endcase
      if (state_ff == S_DONE && out_free) begin
         rsp_tdata_ff <= {2'b00, res_status_ff, res_right_ff, res_left_ff, res_group_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule
`default_nettype wire

>>> hdl/gpw_checker.sv
// port-level checks for group_projector_weights, attached by bind
// depends on gpw_pkg
`default_nettype none
module gpw_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [gpw_pkg::RSP_W-1:0] rsp_tdata
);
   import gpw_pkg::*;

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("request taken during clearing pass");

   // missing node gives all zero fields
   a_no_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[45:44] == ST_NO_NODE |-> rsp_tdata[43:0] == '0)
      else $error("missing node response not zero");

   // error status gives zero weights
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[45:44] == ST_BAD_GROUP || rsp_tdata[45:44] == ST_ZERO_MASS)
      |-> rsp_tdata[43:10] == '0)
      else $error("error response carries weights");

   // weights never exceed one
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:10] <= ONE_WEIGHT && rsp_tdata[43:27] <= ONE_WEIGHT)
      else $error("weight above one");
endmodule

bind group_projector_weights gpw_checker u_gpw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> tb/gpw_checker.sv
// checker for the group projector weights block: watches request and response channels,
// predicts each query response from its own copy of the stores and compares it as a whole
// depends on gpw_pkg
`default_nettype none
module gpw_scoreboard (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [gpw_pkg::REQ_W-1:0] req_tdata,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [gpw_pkg::RSP_W-1:0] rsp_tdata,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [gpw_pkg::CSR_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending,
   output int                             rsp_seen
);
   import gpw_pkg::*;

   typedef struct packed {
      logic [1:0]          status;
      logic [WEIGHT_W-1:0] right_w;
      logic [WEIGHT_W-1:0] left_w;
      logic [GROUP_AW-1:0] label;
   } weights_type;

   logic [GROUP_AW-1:0] grp_of [MAX_NODES];
   logic [PROB_W-1:0]   prob_of [MAX_NODES];
   logic [COUNT_W-1:0]  cnt [GROUP_SLOTS];
   logic [MASS_W-1:0]   mass [GROUP_SLOTS];
   int                  n_loaded;
   logic [GROUP_AW-1:0] top_grp;
   logic [1:0]          kind;
   logic                by_row;
   weights_type         expected_q[$];

   function automatic logic [WEIGHT_W-1:0] inv_sqrt(input longint unsigned c);
      longint unsigned q, r;
      q = 64'd1 << (2 * WFRAC);
      q = q / c;
      r = 0;
      while ((r + 1) * (r + 1) <= q) r++;
      return r[WEIGHT_W-1:0];
   endfunction

   function automatic weights_type project(input int node);
      weights_type o;
      logic [GROUP_AW-1:0] g;
      logic [WEIGHT_W-1:0] w;
      longint unsigned num;
      o = '0;
      if (node >= n_loaded) begin
         o.status = ST_NO_NODE;
         return o;
      end
      g = grp_of[node];
      o.label = g;
      if (top_grp >= n_loaded) o.status = ST_BAD_GROUP;
      else if (kind == KIND_STOCH) begin
         if (mass[g] == 0) o.status = ST_ZERO_MASS;
         else begin
            num = longint'(prob_of[node]) << WFRAC;
            w = WEIGHT_W'(num / mass[g]);
            o.left_w  = by_row ? w : ONE_WEIGHT;
            o.right_w = by_row ? ONE_WEIGHT : w;
         end
      end else begin
         w = inv_sqrt(cnt[g]);
         if (kind == KIND_LAP) begin
            o.left_w  = by_row ? ONE_WEIGHT : w;
            o.right_w = by_row ? w : ONE_WEIGHT;
         end else begin
            o.left_w = w;
            o.right_w = w;
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      logic [1:0] cmd;
      logic [GROUP_AW-1:0] gi;
      weights_type got, exp_w;
      if (reset) begin
         for (int i = 0; i < GROUP_SLOTS; i++) begin
            cnt[i] = '0;
            mass[i] = '0;
         end
         n_loaded = 0;
         top_grp = '0;
         kind = KIND_SYM;
         by_row = 1'b1;
         fail_count <= 0;
         rsp_seen <= 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_KIND) kind = csr_wdata;
            else by_row = csr_wdata[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(weights_type)-1:0];
            rsp_seen <= rsp_seen + 1;
            if (expected_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response %h", got);
            end else begin
               exp_w = expected_q.pop_front();
               if (got !== exp_w) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: exp grp %0d l %0d r %0d st %0d, got grp %0d l %0d r %0d st %0d",
                        exp_w.label, exp_w.left_w, exp_w.right_w, exp_w.status,
                        got.label, got.left_w, got.right_w, got.status);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = req_tdata[1:0];
            gi = req_tdata[11:2];
            case (cmd)
               CMD_LOAD: if (n_loaded < MAX_NODES) begin
                  grp_of[n_loaded] = gi;
                  prob_of[n_loaded] = req_tdata[27:12];
                  cnt[gi] = cnt[gi] + COUNT_W'(1);
                  mass[gi] = mass[gi] + MASS_W'(req_tdata[27:12]);
                  if (gi > top_grp) top_grp = gi;
                  n_loaded++;
               end
               CMD_CLEAR: begin
                  for (int i = 0; i < GROUP_SLOTS; i++) begin
                     cnt[i] = '0;
                     mass[i] = '0;
                  end
                  n_loaded = 0;
                  top_grp = '0;
               end
               CMD_QUERY: expected_q.push_back(project(int'(req_tdata[37:28])));
               default: ;
            endcase
         end
      end
      pending <= expected_q.size();
   end

endmodule
`default_nettype wire

>>> tb/tb.sv
// testbench top for group projector weights: clock, reset, request and csr stimulus, verdict
// depends on gpw_pkg, group_projector_weights, gpw_scoreboard
`default_nettype none
module tb;
   import gpw_pkg::*;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we = 0;
   logic             csr_index = 0;
   logic [CSR_W-1:0] csr_wdata = '0;
   int               fail_count, pending, rsp_seen;
   int               idle_cycles = 0;
   int               hold_off = 0;
   bit               calm = 0;
   int               sent = 0, queries = 0;

   always #5 clock = ~clock;

   group_projector_weights u_dut (.*);
   gpw_scoreboard u_chk (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side: random stall bursts, one long hold-off
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 9);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send(input logic [1:0] cmd, input int g, input int p, input int nd);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         n = $urandom_range(1, 9);
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b0, 10'(nd), 16'(p), 10'(g), cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (cmd == CMD_QUERY) queries++;
   endtask

   task automatic write_csr(input csr_idx_type idx, input int val);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      csr_we <= 0;
   endtask

   // one well-formed graph: loads, then queries with a little noise, then a clear
   task automatic graph_phase(input int nodes, input int groups, input int nq);
      for (int i = 0; i < nodes; i++)
         send(CMD_LOAD, (i < groups) ? i : $urandom_range(0, groups - 1),
              ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535), $urandom);
      for (int i = 0; i < nq; i++) begin
         case ($urandom_range(0, 19))
            0: send(CMD_LOAD, $urandom, $urandom, $urandom);
            1: send(CMD_NOP, $urandom, $urandom, $urandom);
            2: send(CMD_QUERY, $urandom, $urandom, $urandom);
            default: send(CMD_QUERY, $urandom, $urandom, $urandom_range(0, nodes - 1));
         endcase
      end
      send(CMD_CLEAR, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int wait_n;
      repeat (2) @(posedge clock);
      reset <= 0;
      // directed: not loaded, bad group, zero mass, extremes, no-op command
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_QUERY, 'h3ff, 'hffff, 'h3ff);
      send(CMD_LOAD, 'h3ff, 'hffff, 0);
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_CLEAR, 0, 0, 0);
      send(CMD_LOAD, 0, 'hffff, 0);
      send(CMD_LOAD, 1, 0, 0);
      send(CMD_LOAD, 0, 1, 0);
      send(CMD_NOP, 'h3ff, 'hffff, 'h3ff);
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_QUERY, 0, 0, 1);
      send(CMD_QUERY, 0, 0, 3);
      write_csr(CSR_KIND, KIND_STOCH);
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_QUERY, 0, 0, 1);
      send(CMD_QUERY, 0, 0, 2);
      write_csr(CSR_ROW, 0);
      send(CMD_QUERY, 0, 0, 1);
      send(CMD_QUERY, 0, 0, 2);
      write_csr(CSR_KIND, KIND_LAP);
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_CLEAR, 0, 0, 0);
      // full store: 1024 single-group nodes plus one ignored load
      for (int i = 0; i < MAX_NODES + 1; i++) send(CMD_LOAD, 0, $urandom, 0);
      send(CMD_QUERY, 0, 0, 'h3ff);
      write_csr(CSR_KIND, KIND_RSVD);
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_CLEAR, 0, 0, 0);
      // random phases with randomly chosen settings, with one long response hold-off
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_KIND, $urandom_range(0, 3));
         write_csr(CSR_ROW, $urandom_range(0, 1));
         if (ph == 2) hold_off = 400;
         if (ph == 7) calm = 1;
         graph_phase($urandom_range(4, 40), $urandom_range(1, 4), 40);
      end
      req_tvalid <= 0;
      wait_n = 0;
      while (pending != 0 && wait_n < 100000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (100) @(posedge clock);
      $display("run covered %0d requests, %0d queries, %0d responses checked",
               sent, queries, rsp_seen);
      $display("all matrix kinds, both normalizations, empty/full store and error statuses");
      if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
hdl/gpw_pkg.sv
hdl/gpw_ram.sv
hdl/gpw_serial_unit.sv
hdl/group_projector_weights.sv
hdl/gpw_checker.sv
tb/gpw_checker.sv
tb/tb.sv
